/* sv/tmed_pkg.sv */
// types and constants shared by the timed midi event dispatcher
package tmed_pkg;

  localparam int TIME_BITS = 40;
  localparam int MSG_BITS  = 24;

  localparam int LOOKAHEAD_BITS = 20;
  localparam int TOLERANCE_BITS = 16;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [LOOKAHEAD_BITS-1:0] LOOKAHEAD_RESET = 20'd5000;
  localparam logic [TOLERANCE_BITS-1:0] TOLERANCE_RESET = 16'd100;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOKAHEAD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE = 2'd1;

  localparam logic [2:0] OP_QUEUE     = 3'd0;
  localparam logic [2:0] OP_POLL      = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_SET_POS   = 3'd3;
  localparam logic [2:0] OP_NOTES_OFF = 3'd4;

  localparam logic [2:0] KIND_MIDI    = 3'd0;
  localparam logic [2:0] KIND_SUMMARY = 3'd1;
  localparam logic [2:0] KIND_QUEUED  = 3'd2;
  localparam logic [2:0] KIND_DROPPED = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  localparam logic [7:0] CC_STATUS        = 8'hB0;
  localparam logic [7:0] CC_ALL_NOTES_OFF = 8'd123;

  typedef struct packed {
    logic [2:0]           operation;
    logic [TIME_BITS-1:0] time_value;
    logic                 audio_master;
    logic [7:0]           command;
    logic [3:0]           channel;
    logic [6:0]           data_one;
    logic [6:0]           data_two;
  } item_t;

  typedef struct packed {
    logic [2:0]           result_kind;
    logic [MSG_BITS-1:0]  message_word;
    logic [TIME_BITS-1:0] position_out;
    logic                 last;
  } result_t;

endpackage

/* sv/timed_midi_event_dispatcher_unit.sv */
// timed midi event dispatcher: timestamped message queue released against a play position
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-------------------------------
//  item      | item_valid / item_ready      | item   (tmed_pkg::item_t)
//  result    | result_valid / result_ready  | result (tmed_pkg::result_t)
//  config    | cfg_write                    | cfg_index, cfg_data
//
// queue, clear, set position and all-notes-off requests are accepted, then
// executed into the result register; a poll goes through exec and head, then
// emit and fetch for every released event, as the queue memory read is
// registered and the memory is re-read at the head after every release.
// rst is synchronous: indices, count, position and lookahead/tolerance return
// to their reset values; the queue memory itself is not cleared.
// a stalled result holds the block in any state that would load the result
// register; items wait at item_ready low until the sequencer is back in idle.
module timed_midi_event_dispatcher_unit #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  tmed_pkg::item_t                      item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output tmed_pkg::result_t                    result,
  input  logic                                 cfg_write,
  input  logic [tmed_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tmed_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import tmed_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_BITS + MSG_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_SLOT  = IW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HEAD,
    S_EMIT,
    S_FETCH
  } state_t;

  state_t                    state;
  item_t                     cur;
  logic [IW-1:0]             head_index;
  logic [IW-1:0]             tail_index;
  logic [CW-1:0]             entry_count;
  logic [CW-1:0]             released;
  logic [TIME_BITS-1:0]      play_position;
  logic [TIME_BITS-1:0]      batch_time;
  logic [LOOKAHEAD_BITS-1:0] lookahead_window;
  logic [TOLERANCE_BITS-1:0] batch_tolerance_us;

  // queue memory: one entry holds {time, message}
  logic [EW-1:0]             queue_mem [QUEUE_DEPTH];
  logic [EW-1:0]             rd_data;
  logic                      mem_we;

  logic                      out_free;
  logic                      result_load;
  logic [MSG_BITS-1:0]       cur_msg;
  logic [TIME_BITS-1:0]      head_time;
  logic [MSG_BITS-1:0]       head_msg;
  logic [TIME_BITS:0]        elapsed_sum;
  logic [TIME_BITS-1:0]      poll_position;
  logic [TIME_BITS:0]        due_limit;
  logic [TIME_BITS:0]        batch_limit;
  logic                      head_due;
  logic                      in_batch;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
    next_slot = (idx == LAST_SLOT) ? '0 : idx + IW'(1);
  endfunction

  assign item_ready = (state == S_IDLE);
  // result register may be reloaded when empty or being taken this cycle
  assign out_free   = !result_valid || result_ready;

  // states that load the result register this cycle
  assign result_load = out_free &&
                       (((state == S_EXEC) && (cur.operation != OP_POLL)) ||
                        ((state == S_HEAD) && !head_due) ||
                        (state == S_EMIT));

  // packed message: status | data1 at bit 8 | data2 at bit 16
  assign cur_msg = {1'b0, cur.data_two, 1'b0, cur.data_one, cur.command | {4'd0, cur.channel}};

  assign head_time = rd_data[EW-1:MSG_BITS];
  assign head_msg  = rd_data[MSG_BITS-1:0];

  // elapsed mode saturates at the top of the time range
  assign elapsed_sum   = {1'b0, play_position} + {1'b0, cur.time_value};
  assign poll_position = cur.audio_master ? cur.time_value :
                         (elapsed_sum[TIME_BITS] ? '1 : elapsed_sum[TIME_BITS-1:0]);

  // due tests carry one extra bit so the window never wraps
  assign due_limit   = {1'b0, play_position} + (TIME_BITS+1)'(lookahead_window);
  assign batch_limit = {1'b0, batch_time} + (TIME_BITS+1)'(batch_tolerance_us);
  assign head_due    = (entry_count != '0) && ({1'b0, head_time} <= due_limit);
  assign in_batch    = (entry_count != '0) && ({1'b0, head_time} <= batch_limit);

  assign mem_we = (state == S_EXEC) && (cur.operation == OP_QUEUE) &&
                  (entry_count != FULL_COUNT) && out_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem[tail_index] <= {cur.time_value, cur_msg};
    end
    // head is read every cycle; data is used only after the head settles
    rd_data <= queue_mem[head_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead_window   <= LOOKAHEAD_RESET;
      batch_tolerance_us <= TOLERANCE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LOOKAHEAD: lookahead_window   <= cfg_data[LOOKAHEAD_BITS-1:0];
        CFG_TOLERANCE: batch_tolerance_us <= cfg_data[TOLERANCE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_index    <= '0;
      tail_index    <= '0;
      entry_count   <= '0;
      released      <= '0;
      play_position <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (cur.operation == OP_POLL) begin
            // head read is already under way at the unchanged head index
            play_position <= poll_position;
            released      <= '0;
            state         <= S_HEAD;
          end else if (out_free) begin
            result.last <= 1'b1;
            state       <= S_IDLE;
            case (cur.operation)
              OP_QUEUE: begin
                result.message_word <= cur_msg;
                result.position_out <= play_position;
                if (entry_count == FULL_COUNT) begin
                  result.result_kind <= KIND_DROPPED;
                end else begin
                  result.result_kind <= KIND_QUEUED;
                  tail_index         <= next_slot(tail_index);
                  entry_count        <= entry_count + CW'(1);
                end
              end
              OP_CLEAR: begin
                result.result_kind  <= KIND_DONE;
                result.message_word <= '0;
                result.position_out <= play_position;
                head_index          <= '0;
                tail_index          <= '0;
                entry_count         <= '0;
              end
              OP_SET_POS: begin
                result.result_kind  <= KIND_DONE;
                result.message_word <= '0;
                play_position       <= cur.time_value;
                result.position_out <= cur.time_value;
              end
              OP_NOTES_OFF: begin
                result.result_kind  <= KIND_MIDI;
                result.message_word <= {8'd0, CC_ALL_NOTES_OFF,
                                        CC_STATUS | {4'd0, cur.channel}};
                result.position_out <= play_position;
              end
              default: begin
                result.result_kind  <= KIND_DONE;
                result.message_word <= '0;
                result.position_out <= play_position;
              end
            endcase
          end
        end

        S_HEAD: begin
          if (head_due) begin
            // head sets the batch; it always lies within its own window
            batch_time <= head_time;
            state      <= S_EMIT;
          end else if (out_free) begin
            result.result_kind  <= KIND_SUMMARY;
            result.message_word <= '0;
            result.position_out <= play_position;
            result.last         <= 1'b1;
            state               <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            result.position_out <= play_position;
            if (in_batch) begin
              result.result_kind  <= KIND_MIDI;
              result.message_word <= head_msg;
              result.last         <= 1'b0;
              head_index          <= next_slot(head_index);
              entry_count         <= entry_count - CW'(1);
              released            <= released + CW'(1);
              state               <= S_FETCH;
            end else begin
              result.result_kind  <= KIND_SUMMARY;
              result.message_word <= MSG_BITS'(released);
              result.last         <= 1'b1;
              state               <= S_IDLE;
            end
          end
        end

        S_FETCH: begin
          // wait for the read at the new head
          state <= S_EMIT;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/timed_midi_event_dispatcher_unit_tb.sv */
// testbench for the timed midi event dispatcher: random and directed requests checked against a predictor
module timed_midi_event_dispatcher_unit_tb;
  import tmed_pkg::*;

  localparam int QDEPTH        = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int SEGMENT_ITEMS = 75;
  localparam int SEGMENTS      = 6;

  // operation codes the block does not decode
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // lookahead and tolerance per random segment; segment three draws its own
  localparam logic [LOOKAHEAD_BITS-1:0] LA_PLAN [SEGMENTS] =
    '{20'd5000, 20'd0, 20'hFFFFF, 20'd0, 20'd20000, 20'd0};
  localparam logic [TOLERANCE_BITS-1:0] TOL_PLAN [SEGMENTS] =
    '{16'd100, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF};

  // ---------------------------------------------------------------------------
  // scoreboard: keeps its own copy of the event queue, position and settings,
  // turns every accepted request into the results it must produce, and checks
  // each accepted result against the oldest one still awaited
  // ---------------------------------------------------------------------------
  class dispatch_scoreboard;
    logic [TIME_BITS-1:0]      ev_time [QDEPTH];
    logic [MSG_BITS-1:0]       ev_msg  [QDEPTH];
    int unsigned               rd_slot;
    int unsigned               wr_slot;
    int unsigned               held;
    logic [TIME_BITS-1:0]      position;
    logic [LOOKAHEAD_BITS-1:0] lookahead;
    logic [TOLERANCE_BITS-1:0] tolerance;
    result_t                   awaited[$];
    int unsigned               failures;

    function new();
      rd_slot   = 0;
      wr_slot   = 0;
      held      = 0;
      position  = '0;
      lookahead = LOOKAHEAD_RESET;
      tolerance = TOLERANCE_RESET;
      failures  = 0;
    endfunction

    // t <= base + window, worked out one bit wider so nothing wraps
    function bit is_due(logic [TIME_BITS-1:0] t, logic [TIME_BITS-1:0] base,
                        logic [TIME_BITS-1:0] window);
      logic [TIME_BITS:0] reach;
      reach = {1'b0, base} + {1'b0, window};
      return {1'b0, t} <= reach;
    endfunction

    function void expect_result(logic [2:0] kind, logic [MSG_BITS-1:0] msg, logic fin);
      result_t r;
      r.result_kind  = kind;
      r.message_word = msg;
      r.position_out = position;
      r.last         = fin;
      awaited.insert(awaited.size(), r);
    endfunction

    function void note_request(item_t r);
      logic [MSG_BITS-1:0]  packed_msg;
      logic [TIME_BITS:0]   sum;
      logic [TIME_BITS-1:0] batch_head;
      int unsigned          released;
      packed_msg = {1'b0, r.data_two, 1'b0, r.data_one, r.command | {4'h0, r.channel}};
      released   = 0;
      case (r.operation)
        OP_QUEUE: begin
          if (held >= QDEPTH) begin
            // full queue: request dropped, nothing stored
            expect_result(KIND_DROPPED, packed_msg, 1'b1);
          end else begin
            ev_time[wr_slot] = r.time_value;
            ev_msg[wr_slot]  = packed_msg;
            wr_slot = (wr_slot + 1) % QDEPTH;
            held++;
            expect_result(KIND_QUEUED, packed_msg, 1'b1);
          end
        end
        OP_POLL: begin
          if (r.audio_master) begin
            position = r.time_value;
          end else begin
            // elapsed time saturates at the top of the time range
            sum = {1'b0, position} + {1'b0, r.time_value};
            position = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
          end
          // only the front is looked at; later entries wait their turn
          if (held > 0 && is_due(ev_time[rd_slot], position, TIME_BITS'(lookahead))) begin
            batch_head = ev_time[rd_slot];
            while (held > 0 && is_due(ev_time[rd_slot], batch_head, TIME_BITS'(tolerance))) begin
              expect_result(KIND_MIDI, ev_msg[rd_slot], 1'b0);
              rd_slot = (rd_slot + 1) % QDEPTH;
              held--;
              released++;
            end
          end
          expect_result(KIND_SUMMARY, MSG_BITS'(released), 1'b1);
        end
        OP_CLEAR: begin
          rd_slot = 0;
          wr_slot = 0;
          held    = 0;
          expect_result(KIND_DONE, '0, 1'b1);
        end
        OP_SET_POS: begin
          position = r.time_value;
          expect_result(KIND_DONE, '0, 1'b1);
        end
        OP_NOTES_OFF: begin
          expect_result(KIND_MIDI, {8'h00, CC_ALL_NOTES_OFF, CC_STATUS | {4'h0, r.channel}},
                        1'b1);
        end
        default: begin
          expect_result(KIND_DONE, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: kind %0d msg %h pos %0d last %0b",
                   got.result_kind, got.message_word, got.position_out, got.last);
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      if (got.result_kind !== want.result_kind || got.message_word !== want.message_word ||
          got.position_out !== want.position_out || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display({"result mismatch (expected/actual): ",
                    "kind %0d/%0d msg %h/%h pos %0d/%0d last %0b/%0b"},
                   want.result_kind, got.result_kind, want.message_word, got.message_word,
                   want.position_out, got.position_out, want.last, got.last);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block
  // ---------------------------------------------------------------------------
  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      item_valid   = 1'b0;
  logic                      item_ready;
  item_t                     req_payload  = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  result_t                   res_payload;
  logic                      cfg_write    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  // idling odds in percent, per side
  int unsigned send_idle = 35;
  int unsigned recv_idle = 81;

  int unsigned          quiet_cycles    = 0;
  logic [TIME_BITS-1:0] last_event_time = '0;

  dispatch_scoreboard sb = new();

  timed_midi_event_dispatcher_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (req_payload),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (res_payload),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random, redrawn every cycle
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle);
  end

  // values read here are the ones the block saw at this edge
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result(res_payload);
  end

  // watchdog: too long without any request or result moving ends the run
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------
  function automatic item_t make_request(logic [2:0] op, logic [TIME_BITS-1:0] tv,
                                         logic am, logic [7:0] cmd, logic [3:0] ch,
                                         logic [6:0] d1, logic [6:0] d2);
    item_t r;
    r.operation    = op;
    r.time_value   = tv;
    r.audio_master = am;
    r.command      = cmd;
    r.channel      = ch;
    r.data_one     = d1;
    r.data_two     = d2;
    return r;
  endfunction

  function automatic logic [TIME_BITS-1:0] wide_time();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TIME_BITS-1:0];
  endfunction

  // random request with every field drawn; the caller picks op and time
  function automatic item_t scrambled_request(logic [2:0] op, logic [TIME_BITS-1:0] tv);
    return make_request(op, tv, 1'($urandom_range(1)), 8'($urandom_range(255)),
                        4'($urandom_range(15)), 7'($urandom_range(127)),
                        7'($urandom_range(127)));
  endfunction

  // mix: mostly queue and poll near the play position so events get released,
  // with far-off times, jumps, clears and spare codes as noise
  function automatic item_t random_request();
    int unsigned          pick;
    logic [TIME_BITS-1:0] tv;
    logic                 am;
    item_t                r;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(15))
        0:       tv = wide_time();
        1, 2, 3: tv = last_event_time + TIME_BITS'($urandom_range(200));
        default: tv = sb.position + TIME_BITS'($urandom_range(20000));
      endcase
      r = scrambled_request(OP_QUEUE, tv);
    end else if (pick < 82) begin
      am = ($urandom_range(3) == 0);
      if (am) begin
        case ($urandom_range(19))
          0:          tv = wide_time();
          1, 2, 3, 4: tv = sb.position - TIME_BITS'($urandom_range(3000));
          default:    tv = sb.position + TIME_BITS'($urandom_range(20000));
        endcase
      end else begin
        tv = ($urandom_range(39) == 0) ? wide_time() : TIME_BITS'($urandom_range(6000));
      end
      r = scrambled_request(OP_POLL, tv);
      r.audio_master = am;
    end else if (pick < 85) begin
      r = scrambled_request(OP_CLEAR, wide_time());
    end else if (pick < 90) begin
      tv = ($urandom_range(7) == 0) ? wide_time() : TIME_BITS'($urandom_range(2000000));
      r = scrambled_request(OP_SET_POS, tv);
    end else if (pick < 96) begin
      r = scrambled_request(OP_NOTES_OFF, wide_time());
    end else begin
      r = scrambled_request(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), wide_time());
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------

  // valid stays high across back-to-back requests; it only drops for a gap
  task automatic send_request(input item_t r);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    req_payload <= r;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_request(r);
    if (r.operation == OP_QUEUE)
      last_event_time = r.time_value;
  endtask

  // drop valid and wait until every awaited result is in, then let the clock run on
  task automatic settle(input int unsigned tail_cycles);
    item_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (tail_cycles) @(posedge clk);
  endtask

  task automatic load_settings(input logic [LOOKAHEAD_BITS-1:0] la,
                               input logic [TOLERANCE_BITS-1:0] tol);
    cfg_write <= 1'b1;
    cfg_index <= CFG_LOOKAHEAD;
    cfg_data  <= CFG_DATA_BITS'(la);
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_data  <= CFG_DATA_BITS'(tol);
    @(posedge clk);
    cfg_write    <= 1'b0;
    sb.lookahead = la;
    sb.tolerance = tol;
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset settings: lookahead 5000, tolerance 100
    send_request(make_request(OP_POLL, '0, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));       // empty poll
    send_request(make_request(OP_QUEUE, '0, 1'b1, 8'hFF, 4'hF, 7'h7F, 7'h7F));
    send_request(make_request(OP_QUEUE, 40'd50, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));
    send_request(make_request(OP_QUEUE, 40'd400, 1'b0, 8'h90, 4'h3, 7'd60, 7'd100));
    send_request(make_request(OP_QUEUE, 40'd1000000, 1'b0, 8'h80, 4'h9, 7'd60, 7'd0));
    send_request(make_request(OP_POLL, '0, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));       // batch of two
    send_request(make_request(OP_POLL, '0, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));       // lone event
    send_request(make_request(OP_POLL, 40'd10, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));   // head not due
    // an earlier time behind a later head: must wait for the head
    send_request(make_request(OP_QUEUE, 40'd2000, 1'b0, 8'hC0, 4'h5, 7'd12, 7'd34));
    send_request(make_request(OP_POLL, 40'd5000, 1'b1, 8'h00, 4'h0, 7'h00, 7'h00));
    send_request(make_request(OP_POLL, 40'd995000, 1'b1, 8'h00, 4'h0, 7'h00, 7'h00));
    // near the top of the time range: saturation and the no-wrap due test
    send_request(make_request(OP_SET_POS, TIME_MAX - 40'd99, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));
    send_request(make_request(OP_QUEUE, TIME_MAX, 1'b1, 8'hA5, 4'hA, 7'h55, 7'h2A));
    send_request(make_request(OP_POLL, TIME_MAX, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));
    send_request(make_request(OP_QUEUE, TIME_MAX, 1'b0, 8'h5A, 4'h5, 7'h2A, 7'h55));
    send_request(make_request(OP_POLL, '0, 1'b0, 8'hFF, 4'hF, 7'h7F, 7'h7F));
    send_request(make_request(OP_NOTES_OFF, TIME_MAX, 1'b1, 8'h55, 4'h0, 7'h7F, 7'h00));
    send_request(make_request(OP_NOTES_OFF, '0, 1'b0, 8'hAA, 4'hF, 7'h00, 7'h7F));
    send_request(make_request(OP_SPARE_LO, TIME_MAX, 1'b1, 8'hFF, 4'hF, 7'h7F, 7'h7F));
    send_request(make_request(3'(OP_SPARE_LO + 3'd1), '0, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));
    send_request(make_request(OP_SPARE_HI, 40'd777, 1'b1, 8'h12, 4'h3, 7'h45, 7'h67));
    send_request(make_request(OP_QUEUE, 40'd123, 1'b0, 8'h90, 4'h1, 7'd64, 7'd90));
    send_request(make_request(OP_CLEAR, '0, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));
    send_request(make_request(OP_POLL, '0, 1'b1, 8'h00, 4'h0, 7'h00, 7'h00));       // cleared
    send_request(make_request(OP_SET_POS, '0, 1'b0, 8'h00, 4'h0, 7'h00, 7'h00));

    // random part: settings change only once the block has gone idle
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle(8);
      if (seg == 3)
        load_settings(LOOKAHEAD_BITS'($urandom_range(50000)),
                      TOLERANCE_BITS'($urandom_range(500)));
      else
        load_settings(LA_PLAN[seg], TOL_PLAN[seg]);
      // sender light / receiver heavy, then swapped, then no idling at all
      send_idle = (seg < 2) ? 35 : (seg < 4) ? 81 : 0;
      recv_idle = (seg < 2) ? 81 : (seg < 4) ? 35 : 0;
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        if ((sent == 0 && seg % 2 == 0) || $urandom_range(199) == 0) begin
          // overfill the queue so drops are seen and polls release long batches
          repeat (QDEPTH + 2) begin
            send_request(scrambled_request(OP_QUEUE,
                                           sb.position + TIME_BITS'($urandom_range(3000))));
            sent++;
          end
        end else begin
          send_request(random_request());
          sent++;
        end
      end
    end

    settle(20);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
sv/tmed_pkg.sv
sv/timed_midi_event_dispatcher_unit.sv
bench/timed_midi_event_dispatcher_unit_tb.sv
